[design/spnp_pkg.sv]
// Package for the sphere projected nearest point block.
// Holds controller-to-datapath command and status types and fixed constants.
// No dependencies.
`default_nettype none

package spnp_pkg;

    localparam int CNT_W = 6;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic       load;
        logic       capture;
        logic       sq;
        logic       root_init;
        logic       root_step;
        logic       proj;
        logic [1:0] axis;
        logic       scan_init;
        logic       scan_rd;
        logic       publish;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic rd_last;
        logic pipe_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/spnp_ctrl.sv]
// Controller state machine: handles loads and sequences squaring, root, projection, scan and publish.
// Depends on spnp_pkg.
`default_nettype none

module spnp_ctrl #(
    parameter int COORD_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              cmd,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire spnp_pkg::dp_stat_t stat,
    output spnp_pkg::dp_cmd_t      dpcmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQ     = 3'd1;
    localparam logic [2:0] S_ROOT   = 3'd2;
    localparam logic [2:0] S_PROJ   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [spnp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        dpcmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == spnp_pkg::CMD_LOAD)
                    begin
                        dpcmd.load = 1'b1;
                    end
                    else
                    begin
                        dpcmd.capture = 1'b1;
                        state_next    = S_SQ;
                        cnt_next      = '0;
                    end
                end
            end
            S_SQ:
            begin
                dpcmd.sq   = 1'b1;
                dpcmd.axis = cnt_reg[1:0];
                if (cnt_reg == spnp_pkg::CNT_W'(3))
                begin
                    state_next = S_ROOT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                if (cnt_reg == '0)
                    dpcmd.root_init = 1'b1;
                else
                    dpcmd.root_step = 1'b1;
                if (cnt_reg == spnp_pkg::CNT_W'(COORD_BITS))
                begin
                    state_next = S_PROJ;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PROJ:
            begin
                dpcmd.proj = 1'b1;
                dpcmd.axis = cnt_reg[1:0];
                if (cnt_reg == spnp_pkg::CNT_W'(3))
                begin
                    dpcmd.scan_init = 1'b1;
                    state_next      = stat.count_zero ? S_FINISH : S_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                dpcmd.scan_rd = 1'b1;
                if (stat.rd_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    dpcmd.publish  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[design/spnp_dp.sv]
// Datapath: point table, magnitude, integer root, projection and scan pipeline.
// Depends on spnp_pkg; driven by spnp_ctrl commands.
`default_nettype none

module spnp_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [10:0]                  cfg_data,
    input  wire logic [9:0]                   entry_index,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    input  wire logic signed [COORD_BITS-1:0] normal_x,
    input  wire logic signed [COORD_BITS-1:0] normal_y,
    input  wire logic signed [COORD_BITS-1:0] normal_z,
    input  wire spnp_pkg::dp_cmd_t            dpcmd,
    output spnp_pkg::dp_stat_t                stat,
    output logic                              found,
    output logic [9:0]                        nearest_index
);

    localparam int C    = COORD_BITS;
    localparam int F    = COORD_BITS - 3;
    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int AW   = 2 * C;
    localparam int MW   = 2 * C + 2;
    localparam int DW   = 2 * C + 1;
    localparam int SW   = 2 * C + 3;

    logic [10:0]               count_reg;
    logic [CW-1:0]             count_eff;
    logic [31:0]               count_wide;

    logic signed [C-1:0]       v_reg [3];
    logic signed [C-1:0]       n_reg [3];
    logic signed [C-1:0]       u_reg [3];

    logic signed [C-1:0]       sq_sel;
    logic signed [AW-1:0]      sq_full;
    logic [AW-1:0]             sq_prod_reg;
    logic [AW-1:0]             acc_reg;

    logic [AW-1:0]             rem_reg, res_reg, bit_reg;
    logic [AW-1:0]             trial;

    logic signed [C+1:0]       pd;
    logic signed [C-1:0]       n_sel;
    logic signed [MW-1:0]      mul_full;
    logic signed [MW-1:0]      mul_reg;
    logic signed [MW-1:0]      rnd;
    logic signed [MW:0]        usum;
    logic signed [MW:0]        umax, umin;
    logic signed [C-1:0]       usat;

    logic [3*C-1:0]            mem [TABLE_DEPTH];
    logic [3*C-1:0]            rd_data_reg;
    logic                      wr_en;
    logic [IW-1:0]             addr_reg;

    logic                      v0_reg, v1_reg, v2_reg;
    logic [IW-1:0]             idx0_reg, idx1_reg, idx2_reg;
    logic signed [C:0]         dx, dy, dz;
    logic signed [2*C+1:0]     sx, sy, sz;
    logic [DW-1:0]             sqx_reg, sqy_reg, sqz_reg;
    logic [SW-1:0]             dist_reg;
    logic [SW-1:0]             best_reg;
    logic [IW-1:0]             best_idx_reg;
    logic                      best_found_reg;
    logic                      out_found_reg;
    logic [9:0]                out_idx_reg;

    assign count_wide = {21'd0, count_reg};
    assign count_eff  = (count_wide > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_wide);

    assign stat.count_zero = (count_eff == '0);
    assign stat.rd_last    = ((CW'(addr_reg) + CW'(1)) == count_eff);
    assign stat.pipe_busy  = v0_reg || v1_reg || v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_write)
            count_reg <= cfg_data;
    end

    // magnitude squared, one axis per cycle
    assign sq_sel  = v_reg[dpcmd.axis];
    assign sq_full = sq_sel * sq_sel;

    assign trial = res_reg + bit_reg;

    // projection
    assign pd       = (C+2)'(1 << F) - $signed({2'b00, res_reg[C-1:0]});
    assign n_sel    = n_reg[dpcmd.axis];
    assign mul_full = n_sel * pd;
    assign rnd      = (mul_reg + $signed(MW'(1) << (F - 1))) >>> F;
    assign usum     = {{(MW+1-C){v_reg[dpcmd.axis - 2'd1][C-1]}}, v_reg[dpcmd.axis - 2'd1]}
                      + {rnd[MW-1], rnd};
    assign umax     = {{(MW+2-C){1'b0}}, {(C-1){1'b1}}};
    assign umin     = {{(MW+2-C){1'b1}}, {(C-1){1'b0}}};
    assign usat     = (usum > umax) ? umax[C-1:0] :
                      (usum < umin) ? umin[C-1:0] : usum[C-1:0];

    always_ff @(posedge clk)
    begin
        if (dpcmd.capture)
        begin
            v_reg[0] <= pos_x;
            v_reg[1] <= pos_y;
            v_reg[2] <= pos_z;
            n_reg[0] <= normal_x;
            n_reg[1] <= normal_y;
            n_reg[2] <= normal_z;
            acc_reg  <= '0;
        end
        if (dpcmd.sq)
        begin
            if (dpcmd.axis != 2'd3)
                sq_prod_reg <= sq_full;
            if (dpcmd.axis != 2'd0)
                acc_reg <= acc_reg + sq_prod_reg;
        end
        if (dpcmd.root_init)
        begin
            rem_reg <= acc_reg;
            res_reg <= '0;
            bit_reg <= AW'(1) << (AW - 2);
        end
        if (dpcmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (dpcmd.proj)
        begin
            if (dpcmd.axis != 2'd3)
                mul_reg <= mul_full;
            if (dpcmd.axis != 2'd0)
                u_reg[dpcmd.axis - 2'd1] <= usat;
        end
    end

    // point table
    assign wr_en = dpcmd.load && ({22'd0, entry_index} < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[IW'(entry_index)] <= {pos_z, pos_y, pos_x};
        if (dpcmd.scan_rd)
            rd_data_reg <= mem[addr_reg];
    end

    // scan pipeline: read, square, sum, compare
    assign dx = $signed({rd_data_reg[C-1], rd_data_reg[C-1:0]})
              - $signed({u_reg[0][C-1], u_reg[0]});
    assign dy = $signed({rd_data_reg[2*C-1], rd_data_reg[2*C-1:C]})
              - $signed({u_reg[1][C-1], u_reg[1]});
    assign dz = $signed({rd_data_reg[3*C-1], rd_data_reg[3*C-1:2*C]})
              - $signed({u_reg[2][C-1], u_reg[2]});
    assign sx = dx * dx;
    assign sy = dy * dy;
    assign sz = dz * dz;

    always_ff @(posedge clk)
    begin
        if (dpcmd.scan_init)
            addr_reg <= '0;
        else if (dpcmd.scan_rd)
            addr_reg <= addr_reg + 1'b1;
        idx0_reg <= addr_reg;
        idx1_reg <= idx0_reg;
        idx2_reg <= idx1_reg;
        sqx_reg  <= sx[DW-1:0];
        sqy_reg  <= sy[DW-1:0];
        sqz_reg  <= sz[DW-1:0];
        dist_reg <= SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
        if (dpcmd.scan_init)
        begin
            best_idx_reg <= '0;
            best_reg     <= '0;
        end
        else if (v2_reg && (!best_found_reg || dist_reg < best_reg))
        begin
            best_idx_reg <= idx2_reg;
            best_reg     <= dist_reg;
        end
        if (dpcmd.publish)
        begin
            out_found_reg <= best_found_reg;
            out_idx_reg   <= 10'(best_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= dpcmd.scan_rd;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            if (dpcmd.scan_init)
                best_found_reg <= 1'b0;
            else if (v2_reg)
                best_found_reg <= 1'b1;
        end
    end

    assign found         = out_found_reg;
    assign nearest_index = out_idx_reg;

endmodule

`default_nettype wire

[design/sphere_projected_nearest_point.sv]
// Top level of the sphere projected nearest point search.
// Instantiates spnp_ctrl and spnp_dp; uses spnp_pkg.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  config  | cfg_write              | cfg_data (point_count)
//  input   | in_valid / in_stall    | cmd, entry_index, pos_xyz, normal_xyz
//  output  | out_valid / out_stall  | found, nearest_index
//
// A load request writes the table entry and leaves the block ready for the next request.
// A query holds in_stall high through squaring, one root step per cycle, projection,
// then the scan, which reads one table entry per cycle from the table memory.
// Reset clears control and point_count only; table contents stay undefined until loaded.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module sphere_projected_nearest_point #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [10:0]                  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         cmd,
    input  wire logic [9:0]                   entry_index,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    input  wire logic signed [COORD_BITS-1:0] normal_x,
    input  wire logic signed [COORD_BITS-1:0] normal_y,
    input  wire logic signed [COORD_BITS-1:0] normal_z,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              found,
    output logic [9:0]                        nearest_index
);

    spnp_pkg::dp_cmd_t  dpcmd;
    spnp_pkg::dp_stat_t stat;

    spnp_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .dpcmd     (dpcmd)
    );

    spnp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .entry_index   (entry_index),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .dpcmd         (dpcmd),
        .stat          (stat),
        .found         (found),
        .nearest_index (nearest_index)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        dpcmd.publish |-> (!out_valid || !out_stall))
        else $error("result published over a pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        dpcmd.scan_rd |-> !stat.count_zero)
        else $error("table read with empty table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (nearest_index == '0))
        else $error("nonzero index on empty result");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for sphere_projected_nearest_point: loads table points and sends vertex queries.
// Checks each nearest index against an in-bench predictor under random gaps and stalls.
// Depends on spnp_pkg and the sphere_projected_nearest_point RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH = 1024;
    localparam int LARGE_FILL = 336;
    localparam longint ONE = 64'sd8192;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct {
        logic                cmd;
        logic [9:0]          entry;
        logic signed [15:0]  px, py, pz, nx, ny, nz;
    } request_t;

    typedef struct {
        logic       found;
        logic [9:0] index;
    } nearest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [10:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = spnp_pkg::CMD_LOAD;
    logic [9:0] entry_index = '0;
    logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic [9:0] nearest_index;

    longint tab_x[DEPTH], tab_y[DEPTH], tab_z[DEPTH];
    int unsigned point_count = 0;
    int filled = 0;
    nearest_t nearest_q[$];
    int errors = 0;
    int queries_sent = 0, loads_sent = 0, results_seen = 0;
    int cycles = 0;
    int hold_cycles = 0;
    int burst_left = 0;

    always #6 clk = ~clk;

    sphere_projected_nearest_point i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .entry_index(entry_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .nearest_index(nearest_index)
    );

    function automatic longint unsigned int_sqrt(longint unsigned a);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > a) b >>= 2;
        while (b != 0) begin
            if (a >= res + b) begin
                a -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint project(longint v, longint n, longint pd);
        longint u;
        u = v + ((n * pd + 64'sd4096) >>> 13);
        if (u > 32767) u = 32767;
        if (u < -32768) u = -32768;
        return u;
    endfunction

    function automatic nearest_t search_nearest(request_t r);
        nearest_t res;
        longint vx, vy, vz, pd, ux, uy, uz, d, best;
        int unsigned n;
        vx = r.px; vy = r.py; vz = r.pz;
        pd = ONE - longint'(int_sqrt(vx * vx + vy * vy + vz * vz));
        ux = project(vx, r.nx, pd);
        uy = project(vy, r.ny, pd);
        uz = project(vz, r.nz, pd);
        n = point_count > DEPTH ? DEPTH : point_count;
        res.found = 1'b0;
        res.index = '0;
        best = 0;
        for (int i = 0; i < n; i++) begin
            d = (tab_x[i] - ux) * (tab_x[i] - ux) + (tab_y[i] - uy) * (tab_y[i] - uy)
                + (tab_z[i] - uz) * (tab_z[i] - uz);
            if (!res.found || d < best) begin
                res.found = 1'b1;
                res.index = i[9:0];
                best = d;
            end
        end
        return res;
    endfunction

    task automatic send_request(request_t r);
        in_valid <= 1'b1;
        cmd <= r.cmd;
        entry_index <= r.entry;
        pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz;
        normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
        do @(posedge clk); while (in_stall);
        if (r.cmd == spnp_pkg::CMD_LOAD) begin
            tab_x[r.entry] = r.px;
            tab_y[r.entry] = r.py;
            tab_z[r.entry] = r.pz;
            if (r.entry == filled) filled++;
            loads_sent++;
        end else begin
            nearest_q.push_back(search_nearest(r));
            queries_sent++;
        end
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_paced(request_t r);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_request(r);
    endtask

    task automatic wait_idle();
        pause_sender(1);
        while (nearest_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_count(int unsigned v);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data <= v[10:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        point_count = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 16384) - 8192);
        return 16'($urandom());
    endfunction

    function automatic request_t make_load(int e, int x, int y, int z);
        request_t r;
        r.cmd = spnp_pkg::CMD_LOAD; r.entry = e[9:0];
        r.px = 16'(x); r.py = 16'(y); r.pz = 16'(z);
        r.nx = 16'($urandom()); r.ny = 16'($urandom()); r.nz = 16'($urandom());
        return r;
    endfunction

    function automatic request_t make_query(int x, int y, int z, int a, int b, int c);
        request_t r;
        r.cmd = spnp_pkg::CMD_QUERY; r.entry = 10'($urandom());
        r.px = 16'(x); r.py = 16'(y); r.pz = 16'(z);
        r.nx = 16'(a); r.ny = 16'(b); r.nz = 16'(c);
        return r;
    endfunction

    function automatic request_t rand_query();
        return make_query(rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord());
    endfunction

    task automatic test_empty_table();
        send_request(make_query(0, 0, 0, 8192, 0, 0));
        send_request(make_query(32767, -32768, 100, -32768, 32767, 0));
        write_count(0);
        send_request(rand_query());
    endtask

    task automatic test_directed();
        send_request(make_load(0, 8192, 0, 0));
        send_request(make_load(1, -8192, 0, 0));
        send_request(make_load(2, 0, 8192, 0));
        send_request(make_load(3, 0, -8192, 0));
        send_request(make_load(4, 0, 0, 8192));
        send_request(make_load(5, 0, 0, 8192));
        send_request(make_load(6, 32767, 32767, 32767));
        send_request(make_load(7, -32768, -32768, -32768));
        write_count(8);
        send_request(make_query(0, 0, 0, 0, 0, 8192));
        send_request(make_query(0, 0, 0, 0, 0, 0));
        send_request(make_query(32767, 32767, 32767, 32767, 32767, 32767));
        send_request(make_query(32767, 32767, 32767, -32768, -32768, -32768));
        send_request(make_query(-32768, -32768, -32768, 32767, 32767, 32767));
        send_request(make_query(-32768, -32768, -32768, -32768, -32768, -32768));
        send_request(make_query(8192, 0, 0, 8192, 0, 0));
        send_request(make_query(0, -4096, 0, 0, -8192, 0));
        send_request(make_query(5793, 5793, 0, 5793, 5793, 0));
        write_count(1);
        send_request(make_query(-32768, 0, 0, -8192, 0, 0));
    endtask

    task automatic test_large_table();
        for (int e = 0; e < LARGE_FILL; e++)
            send_paced(make_load(e, rand_coord(), rand_coord(), rand_coord()));
        write_count(LARGE_FILL);
        repeat (3) send_paced(rand_query());
        write_count(LARGE_FILL - 17);
        repeat (3) send_paced(rand_query());
    endtask

    task automatic test_backpressure();
        write_count($urandom_range(2, 12));
        hold_cycles = 400;
        repeat (8) send_request(rand_query());
        send_request(make_load($urandom_range(0, 1023), rand_coord(), rand_coord(), 0));
        send_request(rand_query());
        wait_idle();
    endtask

    task automatic test_random();
        request_t r;
        for (int p = 0; p < 12; p++) begin
            if (p == 5) write_count($urandom_range(filled - 64, filled));
            else write_count($urandom_range(1, p % 3 == 0 ? 48 : 16));
            for (int k = 0; k < (p == 5 ? 6 : 18); k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    r = make_load($urandom_range(0, filled < DEPTH ? filled : DEPTH - 1),
                                  rand_coord(), rand_coord(), rand_coord());
                end else begin
                    r = rand_query();
                    if ($urandom_range(0, 3) == 0) begin
                        r.nx = -r.px; r.ny = -r.py; r.nz = -r.pz;
                    end
                end
                send_paced(r);
            end
        end
    endtask

    always @(posedge clk) begin
        nearest_t e;
        int pattern;
        if (out_valid && !out_stall) begin
            results_seen++;
            if (nearest_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b index=%0d",
                         $time, found, nearest_index);
            end else begin
                e = nearest_q.pop_front();
                if (found !== e.found) begin
                    errors++;
                    $display("%0t: found mismatch expected %0b actual %0b",
                             $time, e.found, found);
                end
                if (nearest_index !== e.index) begin
                    errors++;
                    $display("%0t: nearest_index mismatch expected %0d actual %0d",
                             $time, e.index, nearest_index);
                end
            end
        end
        pattern = (cycles / 200) % 4;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else if (pattern == 0) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 9) < pattern * 2);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed();
        test_large_table();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (60) @(posedge clk);
        $display("Covered %0d loads and %0d queries, %0d results checked,",
                 loads_sent, queries_sent, results_seen);
        $display("table sizes from empty up to several hundred points, with random stalls.");
        if (errors == 0 && nearest_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
